// ===== rtl/ll3p_pkg.sv =====
// Shared types and constants for the linked-list three-way partition block.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package ll3p_pkg;

    localparam int ADDR_BITS_DEF = 6;
    localparam int DATA_BITS_DEF = 32;
    localparam int THRESH_BITS   = 32;
    localparam int CLASS_BITS    = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef enum logic [CLASS_BITS-1:0] {
        CLS_NEG  = 2'd0,
        CLS_MID  = 2'd1,
        CLS_HIGH = 2'd2
    } t_class;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_PRIME = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_FLUSH = 7'b0100000,
        S_MISS  = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/ll3p_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ll3p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/ll3p_out_reg.sv =====
// Output register of the result channel: holds one request until taken.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module ll3p_out_reg #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire logic [ADDR_BITS-1:0]        i_address,
    input  wire logic signed [DATA_BITS-1:0] i_value,
    input  wire logic [ADDR_BITS-1:0]        i_next_address,
    input  wire logic                        i_next_null,
    input  wire logic                        i_last,
    input  wire logic                        i_error,
    output logic                             o_free,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [ADDR_BITS-1:0]             o_address,
    output logic signed [DATA_BITS-1:0]      o_value,
    output logic [ADDR_BITS-1:0]             o_next_address,
    output logic                             o_next_null,
    output logic                             o_last,
    output logic                             o_error
);

    logic                        r_valid;
    logic [ADDR_BITS-1:0]        r_address;
    logic signed [DATA_BITS-1:0] r_value;
    logic [ADDR_BITS-1:0]        r_next_address;
    logic                        r_next_null;
    logic                        r_last;
    logic                        r_error;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_address      <= i_address;
            r_value        <= i_value;
            r_next_address <= i_next_address;
            r_next_null    <= i_next_null;
            r_last         <= i_last;
            r_error        <= i_error;
        end
    end

    assign o_valid        = r_valid;
    assign o_address      = r_address;
    assign o_value        = r_value;
    assign o_next_address = r_next_address;
    assign o_next_null    = r_next_null;
    assign o_last         = r_last;
    assign o_error        = r_error;

endmodule

`default_nettype wire

// ===== rtl/linked_list_three_way_partition.sv =====
// Top level of the linked-list three-way partition block: sequencer, node and walk RAMs.
// Depends on ll3p_pkg, ll3p_ram and ll3p_out_reg.
//
// Input channel (i_in_valid / o_in_stall) carries load and run requests.
// A load request writes one node into the node RAM in its accept cycle and
// marks the address valid; the next request may follow in the next cycle.
// A run request walks the list from the head, checking each node's valid mark,
// reading the node from the node RAM and writing it to the walk RAM, then scans
// the walk RAM once per class, one entry per cycle unless a stalled result holds
// the scan; o_in_stall stays high during the whole run.
// A run with a null head is consumed at once and yields nothing.
// Result channel (o_out_valid / i_out_stall) is driven from an output
// register; a stalled result holds and the scan waits on it.
// The threshold register is written through i_cfg_we / i_cfg_data.
// Reset clears the valid marks, the threshold and the channel state; the
// RAM contents are kept and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module linked_list_three_way_partition #(
    parameter int ADDR_BITS = ll3p_pkg::ADDR_BITS_DEF,
    parameter int DATA_BITS = ll3p_pkg::DATA_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic signed [ll3p_pkg::THRESH_BITS-1:0] i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic                                  i_operation,
    input  wire logic [ADDR_BITS-1:0]                  i_node_address,
    input  wire logic signed [DATA_BITS-1:0]           i_node_value,
    input  wire logic [ADDR_BITS-1:0]                  i_next_address,
    input  wire logic                                  i_next_is_null,
    input  wire logic [ADDR_BITS-1:0]                  i_head_address,
    input  wire logic                                  i_head_is_null,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [ADDR_BITS-1:0]                       o_out_address,
    output logic signed [DATA_BITS-1:0]                o_out_value,
    output logic [ADDR_BITS-1:0]                       o_out_next_address,
    output logic                                       o_out_next_null,
    output logic                                       o_last_of_run,
    output logic                                       o_walk_error
);

    localparam int DEPTH    = 1 << ADDR_BITS;
    localparam int CB       = ll3p_pkg::CLASS_BITS;
    localparam int NODE_W   = DATA_BITS + ADDR_BITS + 1;
    localparam int WALK_W   = ADDR_BITS + CB + DATA_BITS;
    localparam int CW       = (DATA_BITS > ll3p_pkg::THRESH_BITS) ? DATA_BITS
                                                                  : ll3p_pkg::THRESH_BITS;
    localparam logic [ADDR_BITS:0] DEPTH_CNT = {1'b1, {ADDR_BITS{1'b0}}};

    ll3p_pkg::t_state r_state, n_state;

    logic signed [ll3p_pkg::THRESH_BITS-1:0] r_threshold;
    logic [DEPTH-1:0]     r_valid_marks;
    logic [ADDR_BITS-1:0] r_ptr, n_ptr;
    logic [ADDR_BITS:0]   r_count, n_count;
    logic                 r_err, n_err;
    logic [ADDR_BITS-1:0] r_idx, n_idx;
    ll3p_pkg::t_class     r_cls, n_cls;
    logic                 r_have, n_have;
    logic [ADDR_BITS-1:0] r_pend_addr, n_pend_addr;
    logic signed [DATA_BITS-1:0] r_pend_value, n_pend_value;

    logic                 w_accept;
    logic [NODE_W-1:0]    w_node_wdata, w_node_rdata;
    logic                 w_node_re;
    logic signed [DATA_BITS-1:0] w_node_value;
    logic [ADDR_BITS-1:0] w_node_next;
    logic                 w_node_null;
    logic signed [CW-1:0] w_val_ext, w_thr_ext;
    ll3p_pkg::t_class     w_new_cls;
    logic                 w_walk_we, w_walk_re;
    logic [WALK_W-1:0]    w_walk_wdata, w_walk_rdata;
    logic [ADDR_BITS-1:0] w_rd_addr;
    logic [CB-1:0]        w_rd_cls;
    logic signed [DATA_BITS-1:0] w_rd_value;
    logic [ADDR_BITS:0]   w_count_inc, w_idx_inc;
    logic                 w_match, w_go, w_last_idx;

    logic                 w_push, w_out_free;
    logic [ADDR_BITS-1:0] w_push_addr, w_push_next;
    logic signed [DATA_BITS-1:0] w_push_value;
    logic                 w_push_nn, w_push_last, w_push_err;

    assign o_in_stall = (r_state != ll3p_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_node_wdata = {i_node_value, i_next_address, i_next_is_null};
    assign {w_node_value, w_node_next, w_node_null} = w_node_rdata;
    assign {w_rd_addr, w_rd_cls, w_rd_value} = w_walk_rdata;

    assign w_val_ext = CW'(w_node_value);
    assign w_thr_ext = CW'(r_threshold);

    always_comb begin
        if (w_val_ext[CW-1]) begin
            w_new_cls = ll3p_pkg::CLS_NEG;
        end else if (w_val_ext <= w_thr_ext) begin
            w_new_cls = ll3p_pkg::CLS_MID;
        end else begin
            w_new_cls = ll3p_pkg::CLS_HIGH;
        end
    end

    assign w_walk_wdata = {r_ptr, w_new_cls, w_node_value};
    assign w_count_inc  = r_count + 1'b1;
    assign w_idx_inc    = {1'b0, r_idx} + 1'b1;
    assign w_last_idx   = (w_idx_inc == r_count);
    assign w_match      = (w_rd_cls == r_cls);
    assign w_go         = !(w_match && r_have) || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_marks <= '0;
        end else if (w_accept && i_operation == ll3p_pkg::OP_LOAD) begin
            r_valid_marks[i_node_address] <= 1'b1;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_count      = r_count;
        n_err        = r_err;
        n_idx        = r_idx;
        n_cls        = r_cls;
        n_have       = r_have;
        n_pend_addr  = r_pend_addr;
        n_pend_value = r_pend_value;
        w_node_re    = 1'b0;
        w_walk_we    = 1'b0;
        w_walk_re    = 1'b0;
        w_push       = 1'b0;
        w_push_addr  = r_pend_addr;
        w_push_value = r_pend_value;
        w_push_next  = w_rd_addr;
        w_push_nn    = 1'b0;
        w_push_last  = 1'b0;
        w_push_err   = 1'b0;
        unique case (r_state)
            ll3p_pkg::S_IDLE: begin
                if (w_accept && i_operation == ll3p_pkg::OP_RUN && !i_head_is_null) begin
                    n_ptr   = i_head_address;
                    n_count = '0;
                    n_err   = 1'b0;
                    n_have  = 1'b0;
                    n_state = ll3p_pkg::S_CHECK;
                end
            end
            ll3p_pkg::S_CHECK: begin
                if (r_valid_marks[r_ptr]) begin
                    w_node_re = 1'b1;
                    n_state   = ll3p_pkg::S_FETCH;
                end else begin
                    n_err   = 1'b1;
                    n_state = (r_count == '0) ? ll3p_pkg::S_MISS : ll3p_pkg::S_PRIME;
                end
            end
            ll3p_pkg::S_FETCH: begin
                w_walk_we = 1'b1;
                n_count   = w_count_inc;
                if (w_node_null) begin
                    n_state = ll3p_pkg::S_PRIME;
                end else if (w_count_inc == DEPTH_CNT) begin
                    n_err   = 1'b1;
                    n_state = ll3p_pkg::S_PRIME;
                end else begin
                    n_ptr   = w_node_next;
                    n_state = ll3p_pkg::S_CHECK;
                end
            end
            ll3p_pkg::S_PRIME: begin
                n_idx     = '0;
                n_cls     = ll3p_pkg::CLS_NEG;
                w_walk_re = 1'b1;
                n_state   = ll3p_pkg::S_SCAN;
            end
            ll3p_pkg::S_SCAN: begin
                if (w_go) begin
                    if (w_match) begin
                        w_push       = r_have;
                        n_have       = 1'b1;
                        n_pend_addr  = w_rd_addr;
                        n_pend_value = w_rd_value;
                    end
                    if (!w_last_idx) begin
                        n_idx     = w_idx_inc[ADDR_BITS-1:0];
                        w_walk_re = 1'b1;
                    end else if (r_cls == ll3p_pkg::CLS_HIGH) begin
                        n_state = ll3p_pkg::S_FLUSH;
                    end else begin
                        n_idx     = '0;
                        n_cls     = (r_cls == ll3p_pkg::CLS_NEG) ? ll3p_pkg::CLS_MID
                                                                 : ll3p_pkg::CLS_HIGH;
                        w_walk_re = 1'b1;
                    end
                end
            end
            ll3p_pkg::S_FLUSH: begin
                w_push_next = '0;
                w_push_nn   = 1'b1;
                w_push_last = 1'b1;
                w_push_err  = r_err;
                if (w_out_free) begin
                    w_push  = 1'b1;
                    n_state = ll3p_pkg::S_IDLE;
                end
            end
            ll3p_pkg::S_MISS: begin
                w_push_addr  = r_ptr;
                w_push_value = '0;
                w_push_next  = '0;
                w_push_nn    = 1'b1;
                w_push_last  = 1'b1;
                w_push_err   = 1'b1;
                if (w_out_free) begin
                    w_push  = 1'b1;
                    n_state = ll3p_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ll3p_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ll3p_pkg::S_IDLE;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_have  <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_count      <= n_count;
        r_err        <= n_err;
        r_idx        <= n_idx;
        r_cls        <= n_cls;
        r_pend_addr  <= n_pend_addr;
        r_pend_value <= n_pend_value;
    end

    ll3p_ram #(
        .WIDTH (NODE_W),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_operation == ll3p_pkg::OP_LOAD),
        .i_waddr (i_node_address),
        .i_wdata (w_node_wdata),
        .i_re    (w_node_re),
        .i_raddr (r_ptr),
        .o_rdata (w_node_rdata)
    );

    ll3p_ram #(
        .WIDTH (WALK_W),
        .DEPTH (DEPTH)
    ) u_walk_ram (
        .i_clk   (i_clk),
        .i_we    (w_walk_we),
        .i_waddr (r_count[ADDR_BITS-1:0]),
        .i_wdata (w_walk_wdata),
        .i_re    (w_walk_re),
        .i_raddr (n_idx),
        .o_rdata (w_walk_rdata)
    );

    ll3p_out_reg #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (w_push),
        .i_address      (w_push_addr),
        .i_value        (w_push_value),
        .i_next_address (w_push_next),
        .i_next_null    (w_push_nn),
        .i_last         (w_push_last),
        .i_error        (w_push_err),
        .o_free         (w_out_free),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_address      (o_out_address),
        .o_value        (o_out_value),
        .o_next_address (o_out_next_address),
        .o_next_null    (o_out_next_null),
        .o_last         (o_last_of_run),
        .o_error        (o_walk_error)
    );

endmodule

`default_nettype wire

// ===== rtl/ll3p_checker.sv =====
// Port-level assertions for the linked-list three-way partition block, bound to the top.
// Depends on ll3p_pkg and linked_list_three_way_partition.
`timescale 1ns / 1ps
`default_nettype none

module ll3p_checker #(
    parameter int ADDR_BITS = ll3p_pkg::ADDR_BITS_DEF
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic                 i_operation,
    input wire logic                 i_head_is_null,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [ADDR_BITS-1:0] o_out_next_address,
    input wire logic                 o_out_next_null,
    input wire logic                 o_last_of_run,
    input wire logic                 o_walk_error
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result request dropped");

    a_last_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_next_null == o_last_of_run))
        else $error("null next and last mark disagree");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_walk_error |-> o_last_of_run)
        else $error("walk error on a result that is not last");

    a_null_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_next_null |-> (o_out_next_address == '0))
        else $error("null next carries a nonzero address");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_operation == ll3p_pkg::OP_RUN && !i_head_is_null
        |=> o_in_stall)
        else $error("block not busy after a run request");

endmodule

bind linked_list_three_way_partition ll3p_checker #(
    .ADDR_BITS (ADDR_BITS)
) u_ll3p_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .i_operation        (i_operation),
    .i_head_is_null     (i_head_is_null),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_out_next_address (o_out_next_address),
    .o_out_next_null    (o_out_next_null),
    .o_last_of_run      (o_last_of_run),
    .o_walk_error       (o_walk_error)
);

`default_nettype wire
